FILE: design/obis_pkg.sv
// Shared types, constants and helpers for the OBIS value extractor.
package obis_pkg;

    localparam int MAX_DATAGRAM_BYTES = 1024;
    localparam int SEARCH_START       = 28;
    localparam int IDX_W              = $clog2(MAX_DATAGRAM_BYTES + 1);
    localparam int MATCH_FIRST        = SEARCH_START + 3;
    localparam int DIV_STEPS          = 64;
    localparam int STEP_W             = $clog2(DIV_STEPS);

    localparam logic [2:0] REG_CHANNEL      = 3'd0;
    localparam logic [2:0] REG_QUANTITY     = 3'd1;
    localparam logic [2:0] REG_MEASURE_TYPE = 3'd2;
    localparam logic [2:0] REG_TARIFF       = 3'd3;
    localparam logic [2:0] REG_DIVISOR      = 3'd4;
    localparam logic [2:0] REG_WIDTH        = 3'd5;

    localparam logic [1:0] WIDTH_NONE  = 2'd0;
    localparam logic [1:0] WIDTH_FOUR  = 2'd1;
    localparam logic [1:0] WIDTH_EIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] divisor;
        logic [1:0]  width;
    } cfg_t;

    typedef struct packed {
        logic byte_take;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

    function automatic logic [3:0] width_bytes(input logic [1:0] code);
        logic [3:0] n;
        case (code)
            WIDTH_FOUR:  n = 4'd4;
            WIDTH_EIGHT: n = 4'd8;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: design/obis_ctrl.sv
// Controller: byte intake, divide sequencing and output slot handshake.
module obis_ctrl
    import obis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    last_byte,
    output logic    in_stall,
    input  logic    out_stall,
    output logic    out_valid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && last_byte)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.byte_take = in_valid;
                cmd.div_load  = in_valid && last_byte;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transfer");

    a_load_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> (state_reg == ST_DIVIDE))
        else $error("final byte did not start the divide");

    a_divide_runs_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && !status.div_last) |=> (state_reg == ST_DIVIDE))
        else $error("divide left early");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

FILE: design/obis_dp.sv
// Datapath: identifier search, value capture, restoring divider, result register.
module obis_dp
    import obis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cmd_t         cmd,
    output status_t      status,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         found,
    output logic [63:0]  quotient,
    output logic [31:0]  remainder,
    output logic         short_read
);

    logic [IDX_W-1:0]  byte_index_reg;
    logic [31:0]       word_window_reg;
    logic [IDX_W-1:0]  kept_offset_reg;
    logic              pending_match_reg;
    logic [63:0]       value_shift_reg;
    logic [3:0]        value_bytes_seen_reg;

    logic [63:0]       quo_reg;
    logic [32:0]       rem_reg;
    logic [31:0]       divisor_reg;
    logic [STEP_W-1:0] step_cnt_reg;
    logic              found_hold_reg;
    logic              short_hold_reg;

    logic [63:0]       quotient_reg;
    logic [31:0]       remainder_reg;
    logic              found_reg;
    logic              short_read_reg;

    logic              in_range;
    logic [3:0]        n_bytes;
    logic [IDX_W-1:0]  kept_eff;
    logic [31:0]       window_new;
    logic [IDX_W-1:0]  idx_rel;
    logic              aligned;
    logic              match;
    logic [IDX_W-1:0]  cap_rel;
    logic              capture;
    logic [63:0]       shift_new;
    logic [63:0]       shift_fin;
    logic [3:0]        seen_fin;
    logic [IDX_W-1:0]  kept_fin;
    logic [3:0]        pad_bytes;
    logic [6:0]        pad_bits;
    logic [63:0]       raw;
    logic              has_value;
    logic [32:0]       rem_shift;
    logic              rem_ge;

    assign in_range   = byte_index_reg < IDX_W'(MAX_DATAGRAM_BYTES);
    assign n_bytes    = width_bytes(cfg.width);
    assign kept_eff   = pending_match_reg ? byte_index_reg : kept_offset_reg;
    assign window_new = {word_window_reg[23:0], data_byte};
    assign idx_rel    = byte_index_reg - IDX_W'(MATCH_FIRST);
    assign aligned    = (byte_index_reg >= IDX_W'(MATCH_FIRST)) && (idx_rel[1:0] == 2'b00);
    assign match      = (kept_eff == '0) && aligned && (window_new == cfg.ident) && !last_byte;
    assign cap_rel    = byte_index_reg - kept_eff;
    assign capture    = (kept_eff != '0) && (byte_index_reg >= kept_eff)
                        && (cap_rel < IDX_W'(n_bytes)) && (value_bytes_seen_reg < 4'd8);
    assign shift_new  = {value_shift_reg[55:0], data_byte};

    assign shift_fin  = (in_range && capture) ? shift_new : value_shift_reg;
    assign seen_fin   = (in_range && capture) ? value_bytes_seen_reg + 4'd1
                                              : value_bytes_seen_reg;
    assign kept_fin   = in_range ? kept_eff : kept_offset_reg;
    assign pad_bytes  = (seen_fin < n_bytes) ? n_bytes - seen_fin : 4'd0;
    assign pad_bits   = {pad_bytes, 3'b000};
    assign has_value  = (kept_fin != '0) && (n_bytes != 4'd0);

    always_comb
    begin
        raw = shift_fin << pad_bits;
        if (cfg.width == WIDTH_FOUR)
        begin
            raw[63:32] = 32'd0;
        end
    end

    // restoring divide, one quotient bit per step
    assign rem_shift = {rem_reg[31:0], quo_reg[63]};
    assign rem_ge    = rem_shift >= {1'b0, divisor_reg};

    assign status.div_last = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg       <= '0;
            word_window_reg      <= '0;
            kept_offset_reg      <= '0;
            pending_match_reg    <= 1'b0;
            value_shift_reg      <= '0;
            value_bytes_seen_reg <= '0;
        end
        else if (cmd.byte_take)
        begin
            if (in_range)
            begin
                kept_offset_reg   <= kept_eff;
                word_window_reg   <= window_new;
                pending_match_reg <= match;
                byte_index_reg    <= byte_index_reg + IDX_W'(1);
                if (capture)
                begin
                    value_shift_reg      <= shift_new;
                    value_bytes_seen_reg <= value_bytes_seen_reg + 4'd1;
                end
            end
            if (last_byte)
            begin
                byte_index_reg       <= '0;
                word_window_reg      <= '0;
                pending_match_reg    <= 1'b0;
                value_shift_reg      <= '0;
                value_bytes_seen_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_cnt_reg <= step_cnt_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg        <= has_value ? raw : 64'd0;
            divisor_reg    <= has_value ? cfg.divisor : 32'd1;
            rem_reg        <= '0;
            found_hold_reg <= kept_fin != '0;
            short_hold_reg <= has_value && (seen_fin < n_bytes);
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[62:0], rem_ge};
            rem_reg <= rem_ge ? rem_shift - {1'b0, divisor_reg} : rem_shift;
        end
        if (cmd.out_load)
        begin
            quotient_reg   <= quo_reg;
            remainder_reg  <= rem_reg[31:0];
            found_reg      <= found_hold_reg;
            short_read_reg <= short_hold_reg;
        end
    end

    assign quotient   = quotient_reg;
    assign remainder  = remainder_reg;
    assign found      = found_reg;
    assign short_read = short_read_reg;

endmodule

FILE: design/obis_value_extractor.sv
// Top level: configuration registers, controller and datapath.
// Bytes within a datagram are taken one per cycle with no stall.
// The final byte starts a 64-step shift-subtract divide (one quotient bit per cycle);
// its result is presented after the divide ends, later while the output stalls,
// and input is stalled from the final byte's transfer until the result enters the output register.
// Reset clears all search and capture state, the kept offset and the output valid;
// registers reset to identifier zero, divisor 1 and four-byte width.
module obis_value_extractor
    import obis_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         found,
    output logic [63:0]  quotient,
    output logic [31:0]  remainder,
    output logic         short_read,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [7:0]  obis_channel_reg;
    logic [7:0]  obis_quantity_reg;
    logic [7:0]  obis_measure_type_reg;
    logic [7:0]  obis_tariff_reg;
    logic [31:0] value_divisor_reg;
    logic [1:0]  value_width_reg;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obis_channel_reg      <= 8'd0;
            obis_quantity_reg     <= 8'd0;
            obis_measure_type_reg <= 8'd0;
            obis_tariff_reg       <= 8'd0;
            value_divisor_reg     <= 32'd1;
            value_width_reg       <= WIDTH_FOUR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CHANNEL:      obis_channel_reg      <= cfg_data[7:0];
                REG_QUANTITY:     obis_quantity_reg     <= cfg_data[7:0];
                REG_MEASURE_TYPE: obis_measure_type_reg <= cfg_data[7:0];
                REG_TARIFF:       obis_tariff_reg       <= cfg_data[7:0];
                REG_DIVISOR:      value_divisor_reg     <= cfg_data;
                REG_WIDTH:        value_width_reg       <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.ident   = {obis_channel_reg, obis_quantity_reg,
                          obis_measure_type_reg, obis_tariff_reg};
    assign cfg.divisor = value_divisor_reg;
    assign cfg.width   = value_width_reg;

    obis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (last_byte),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    obis_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .found      (found),
        .quotient   (quotient),
        .remainder  (remainder),
        .short_read (short_read)
    );

endmodule
